>>> rtl/awc_pkg.sv
package awc_pkg;

   // timing base
   localparam int unsigned TICKS_PER_SECOND = 1000;

   // time of day arithmetic
   localparam int unsigned SEC_W = 17;
   localparam int unsigned DAY_SECS = 86400;
   localparam int unsigned HOUR_SECS = 3600;
   localparam int unsigned MIN_SECS = 60;

   // back datapath: working value holds up to a full 32-bit count plus a day
   localparam int unsigned VAL_W = 33;
   localparam int unsigned QUOT_W = 17;

   // elapsed seconds: (diff * SEC_RECIP) >> SEC_SHIFT, exact for any 32-bit diff
   localparam int unsigned SEC_SHIFT = 32 + $clog2(TICKS_PER_SECOND);
   localparam longint unsigned SEC_RECIP =
      ((64'd1 << SEC_SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);

   // days: drop 7 low bits (86400 = 675 << 7), then multiply by 1/675
   localparam int unsigned DAY_PRE = 7;
   localparam int unsigned DAY_DIV = DAY_SECS >> DAY_PRE;
   localparam int unsigned DAY_SHIFT = (VAL_W - DAY_PRE) + $clog2(DAY_DIV);
   localparam longint unsigned DAY_RECIP =
      ((64'd1 << DAY_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV);

   // hours: drop 4 low bits (3600 = 225 << 4), operand below 2^13
   localparam int unsigned HOUR_PRE = 4;
   localparam int unsigned HOUR_DIV = HOUR_SECS >> HOUR_PRE;
   localparam int unsigned HOUR_SHIFT = 13 + $clog2(HOUR_DIV);
   localparam int unsigned HOUR_RECIP =
      ((32'd1 << HOUR_SHIFT) + HOUR_DIV - 32'd1) / HOUR_DIV;

   // minutes: drop 2 low bits (60 = 15 << 2), operand below 2^10
   localparam int unsigned MIN_PRE = 2;
   localparam int unsigned MIN_DIV = MIN_SECS >> MIN_PRE;
   localparam int unsigned MIN_SHIFT = 10 + $clog2(MIN_DIV);
   localparam int unsigned MIN_RECIP =
      ((32'd1 << MIN_SHIFT) + MIN_DIV - 32'd1) / MIN_DIV;

   // function codes of the request
   localparam logic [1:0] FN_SET = 2'd0;
   localparam logic [1:0] FN_STOP = 2'd1;
   localparam logic [1:0] FN_TICK = 2'd2;

   // ASCII codes
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_COLON = 8'h3A;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;
   localparam logic [7:0] ASCII_NUL = 8'h00;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  space_char;
      logic [7:0]  hour_tens_char;
      logic [7:0]  hour_ones_char;
      logic [7:0]  first_colon_char;
      logic [7:0]  minute_tens_char;
      logic [7:0]  minute_ones_char;
      logic [7:0]  second_colon_char;
      logic [7:0]  second_tens_char;
      logic [7:0]  second_ones_char;
      logic [7:0]  terminator_char;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [5:0] out_hour_tens;
      logic [5:0] out_hour_ones;
      logic [5:0] out_minute_tens;
      logic [5:0] out_minute_ones;
      logic [5:0] out_second_tens;
      logic [5:0] out_second_ones;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_SET,
      CMD_STOP,
      CMD_TICK
   } cmd_kind_type;

   // classified command passed from front to back
   typedef struct packed {
      cmd_kind_type kind;
      logic [4:0]   hour;
      logic [5:0]   minute;
      logic [5:0]   second;
      logic [31:0]  now_ms;
   } cmd_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SEC,
      BK_SUM,
      BK_DAY_Q,
      BK_DAY_R,
      BK_HOUR_Q,
      BK_HOUR_R,
      BK_MIN_Q,
      BK_MIN_R,
      BK_OUT
   } back_state_type;

endpackage

>>> rtl/awc_front.sv
module awc_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  awc_pkg::req_type req_data,
   input  logic             queue_full,
   output logic             push,
   output awc_pkg::cmd_type cmd
);
   import awc_pkg::*;

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= ASCII_ZERO) && (c <= ASCII_NINE);
   endfunction

   // binary value of two ASCII digits, valid only when both are digits
   function automatic logic [6:0] two_digits(input logic [7:0] t, input logic [7:0] o);
      two_digits = 7'(t[3:0]) * 7'd10 + 7'(o[3:0]);
   endfunction

   logic [6:0] hour_val;
   logic [6:0] minute_val;
   logic [6:0] second_val;
   logic       format_ok;
   logic       digits_ok;
   logic       range_ok;
   logic       set_ok;
   logic       keep;

   // field checks of a set command
   always_comb begin
      hour_val = two_digits(req_data.hour_tens_char, req_data.hour_ones_char);
      minute_val = two_digits(req_data.minute_tens_char, req_data.minute_ones_char);
      second_val = two_digits(req_data.second_tens_char, req_data.second_ones_char);
      format_ok = (req_data.space_char == ASCII_SPACE) &&
                  (req_data.first_colon_char == ASCII_COLON) &&
                  (req_data.second_colon_char == ASCII_COLON) &&
                  (req_data.terminator_char == ASCII_NUL);
      digits_ok = is_digit(req_data.hour_tens_char) && is_digit(req_data.hour_ones_char) &&
                  is_digit(req_data.minute_tens_char) &&
                  is_digit(req_data.minute_ones_char) &&
                  is_digit(req_data.second_tens_char) &&
                  is_digit(req_data.second_ones_char);
      range_ok = (hour_val <= 7'd23) && (minute_val <= 7'd59) && (second_val <= 7'd59);
      set_ok = format_ok && digits_ok && range_ok;
   end

   // classify; bad sets and unused codes are dropped here
   always_comb begin
      cmd.hour = hour_val[4:0];
      cmd.minute = minute_val[5:0];
      cmd.second = second_val[5:0];
      cmd.now_ms = req_data.now_ms;
      cmd.kind = CMD_TICK;
      keep = 1'b0;
      case (req_data.func)
         FN_SET: begin
            cmd.kind = CMD_SET;
            keep = set_ok;
         end
         FN_STOP: begin
            cmd.kind = CMD_STOP;
            keep = 1'b1;
         end
         FN_TICK: begin
            cmd.kind = CMD_TICK;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = !queue_full;
   assign push = req_valid && req_ready && keep;

endmodule

>>> rtl/awc_queue.sv
module awc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  awc_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output awc_pkg::cmd_type pop_data
);
   import awc_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && pop_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/awc_back.sv
module awc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  awc_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output awc_pkg::rsp_type rsp_data
);
   import awc_pkg::*;

   // tens digit of a value below 64: (v * 13) >> 7
   function automatic logic [3:0] tens_of(input logic [5:0] v);
      logic [10:0] p;
      p = 11'(v) * 11'd13;
      tens_of = p[10:7];
   endfunction

   function automatic logic [3:0] ones_of(input logic [5:0] v);
      logic [6:0] t;
      t = 7'(tens_of(v)) * 7'd10;
      ones_of = 4'(7'(v) - t);
   endfunction

   function automatic logic [5:0] ascii_of(input logic [3:0] d);
      ascii_of = ASCII_ZERO[5:0] + 6'(d);
   endfunction

   back_state_type    state_ff;
   back_state_type    state_in;
   logic              running_ff;
   logic              running_in;
   logic [SEC_W-1:0]  set_secs_ff;
   logic [SEC_W-1:0]  set_secs_in;
   logic [31:0]       base_ms_ff;
   logic [31:0]       base_ms_in;
   logic [VAL_W-1:0]  val_ff;
   logic [VAL_W-1:0]  val_in;
   logic [QUOT_W-1:0] quot_ff;
   logic [QUOT_W-1:0] quot_in;
   logic [4:0]        hour_ff;
   logic [4:0]        hour_in;
   logic [5:0]        min_ff;
   logic [5:0]        min_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   logic [64:0]       sec_prod;
   logic [52:0]       day_prod;
   logic [26:0]       hour_prod;
   logic [20:0]       min_prod;
   logic              out_free;
   logic              tick_go;

   // reciprocal multipliers, one used per step
   always_comb begin
      sec_prod = 65'(val_ff[31:0]) * 65'(SEC_RECIP);
      day_prod = 53'(val_ff[VAL_W-1:DAY_PRE]) * 53'(DAY_RECIP);
      hour_prod = 27'(val_ff[16:HOUR_PRE]) * 27'(HOUR_RECIP);
      min_prod = 21'(val_ff[11:MIN_PRE]) * 21'(MIN_RECIP);
      out_free = !rsp_valid_ff || rsp_ready;
      tick_go = cmd_valid && (cmd.kind == CMD_TICK) && running_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (tick_go) begin
               state_in = BK_SEC;
            end
         end
         BK_SEC: begin
            state_in = BK_SUM;
         end
         BK_SUM: begin
            state_in = BK_DAY_Q;
         end
         BK_DAY_Q: begin
            state_in = BK_DAY_R;
         end
         BK_DAY_R: begin
            state_in = BK_HOUR_Q;
         end
         BK_HOUR_Q: begin
            state_in = BK_HOUR_R;
         end
         BK_HOUR_R: begin
            state_in = BK_MIN_Q;
         end
         BK_MIN_Q: begin
            state_in = BK_MIN_R;
         end
         BK_MIN_R: begin
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_pop = 1'b0;
      running_in = running_ff;
      set_secs_in = set_secs_ff;
      base_ms_in = base_ms_ff;
      val_in = val_ff;
      quot_in = quot_ff;
      hour_in = hour_ff;
      min_in = min_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         BK_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_SET: begin
                     set_secs_in = SEC_W'(cmd.hour) * SEC_W'(HOUR_SECS) +
                                   SEC_W'(cmd.minute) * SEC_W'(MIN_SECS) +
                                   SEC_W'(cmd.second);
                     base_ms_in = cmd.now_ms;
                     running_in = 1'b1;
                  end
                  CMD_STOP: begin
                     running_in = 1'b0;
                  end
                  default: begin
                     val_in = VAL_W'(cmd.now_ms - base_ms_ff);
                  end
               endcase
            end
         end
         BK_SEC: begin
            // whole seconds elapsed
            val_in = VAL_W'(32'(sec_prod >> SEC_SHIFT));
         end
         BK_SUM: begin
            val_in = val_ff + VAL_W'(set_secs_ff);
         end
         BK_DAY_Q: begin
            quot_in = QUOT_W'(day_prod >> DAY_SHIFT);
         end
         BK_DAY_R: begin
            // time of day in seconds
            val_in = val_ff - VAL_W'(quot_ff) * VAL_W'(DAY_SECS);
         end
         BK_HOUR_Q: begin
            hour_in = 5'(hour_prod >> HOUR_SHIFT);
         end
         BK_HOUR_R: begin
            val_in = val_ff - VAL_W'(hour_ff) * VAL_W'(HOUR_SECS);
         end
         BK_MIN_Q: begin
            min_in = 6'(min_prod >> MIN_SHIFT);
         end
         BK_MIN_R: begin
            // seconds left over
            val_in = val_ff - VAL_W'(min_ff) * VAL_W'(MIN_SECS);
         end
         BK_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.out_hour_tens = ascii_of(tens_of(6'(hour_ff)));
               rsp_in.out_hour_ones = ascii_of(ones_of(6'(hour_ff)));
               rsp_in.out_minute_tens = ascii_of(tens_of(min_ff));
               rsp_in.out_minute_ones = ascii_of(ones_of(min_ff));
               rsp_in.out_second_tens = ascii_of(tens_of(val_ff[5:0]));
               rsp_in.out_second_ones = ascii_of(ones_of(val_ff[5:0]));
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         running_ff <= 1'b0;
         set_secs_ff <= '0;
         base_ms_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         running_ff <= running_in;
         set_secs_ff <= set_secs_in;
         base_ms_ff <= base_ms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      quot_ff <= quot_in;
      hour_ff <= hour_in;
      min_ff <= min_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

>>> rtl/ascii_settable_wall_clock.sv
// Wall clock set by an ASCII "HH:MM:SS" command. The front checks each
// request as it arrives (one transaction per cycle while the two-entry
// command queue has room); malformed or out-of-range set commands and
// unused function codes are dropped there. The back executes set and stop
// commands in its idle state. A tick while running passes through these
// steps in the back: dequeue and form the elapsed tick count, turn it into
// whole seconds by reciprocal multiplication, add the set time, a quotient
// step and then a remainder step each for the day wrap, the hour split and
// the minute split, and load the result register, which waits there
// while the receiver stalls. Ticks while stopped, set and stop commands
// produce no response transaction.
module ascii_settable_wall_clock (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  awc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output awc_pkg::rsp_type rsp_data
);
   import awc_pkg::*;

   cmd_type push_cmd;
   cmd_type pop_cmd;
   logic    push;
   logic    queue_full;
   logic    pop;
   logic    pop_valid;

   awc_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   awc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_cmd)
   );

   awc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import awc_pkg::*;

   // func code the block must ignore
   localparam logic [1:0] FN_UNUSED = 2'd3;
   // longest wall-time jump between two random requests, in ms
   localparam int unsigned LONG_JUMP_MS = 100_000_000;
   // quiet cycles after the last reading, many times the tick latency
   localparam int unsigned SETTLE_CYCLES = 100;
   localparam int unsigned DRAIN_GUARD = 20_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   ascii_settable_wall_clock dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // predicted clock state
   logic        clk_running = 1'b0;
   logic [4:0]  clk_hour = '0;
   logic [5:0]  clk_minute = '0;
   logic [5:0]  clk_second = '0;
   logic [31:0] clk_base_ms = '0;

   rsp_type     pending_readings[$];

   int unsigned error_count = 0;
   int unsigned sent_count = 0;
   int unsigned readings_checked = 0;
   int unsigned sets_taken = 0;
   int unsigned sets_dropped = 0;
   int unsigned stop_count = 0;
   int unsigned effective_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic [31:0] wall_ms = '0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic bit is_ascii_digit(input logic [7:0] c);
      return c >= ASCII_ZERO && c <= ASCII_NINE;
   endfunction

   function automatic int unsigned digit_pair(input logic [7:0] tens, input logic [7:0] ones);
      return (int'(tens) - int'(ASCII_ZERO)) * 10 + (int'(ones) - int'(ASCII_ZERO));
   endfunction

   // Apply one accepted transaction to the predicted clock; returns 1 with the
   // expected reading when a tick shows the time.
   function automatic bit advance_clock(input req_type r, output rsp_type reading);
      bit              framed;
      int unsigned     hh, mm, ss, elapsed_s, tod;
      longint unsigned total;
      logic [31:0]     delta;
      reading = '0;
      case (r.func)
         FN_SET: begin
            framed = r.space_char == ASCII_SPACE && r.first_colon_char == ASCII_COLON &&
                     r.second_colon_char == ASCII_COLON && r.terminator_char == ASCII_NUL &&
                     is_ascii_digit(r.hour_tens_char) && is_ascii_digit(r.hour_ones_char) &&
                     is_ascii_digit(r.minute_tens_char) && is_ascii_digit(r.minute_ones_char) &&
                     is_ascii_digit(r.second_tens_char) && is_ascii_digit(r.second_ones_char);
            if (framed) begin
               hh = digit_pair(r.hour_tens_char, r.hour_ones_char);
               mm = digit_pair(r.minute_tens_char, r.minute_ones_char);
               ss = digit_pair(r.second_tens_char, r.second_ones_char);
               framed = hh <= 23 && mm <= 59 && ss <= 59;
            end
            if (framed) begin
               clk_hour    = 5'(hh);
               clk_minute  = 6'(mm);
               clk_second  = 6'(ss);
               clk_base_ms = r.now_ms;
               clk_running = 1'b1;
               sets_taken++;
               effective_count++;
            end else begin
               sets_dropped++;
            end
            return 1'b0;
         end
         FN_STOP: begin
            clk_running = 1'b0;
            stop_count++;
            effective_count++;
            return 1'b0;
         end
         FN_TICK: begin
            if (!clk_running) return 1'b0;
            delta = r.now_ms - clk_base_ms;
            elapsed_s = delta / TICKS_PER_SECOND;
            total = 64'(clk_hour) * HOUR_SECS + 64'(clk_minute) * MIN_SECS +
                    64'(clk_second) + 64'(elapsed_s);
            tod = int'(total % DAY_SECS);
            hh = tod / HOUR_SECS;
            mm = (tod / MIN_SECS) % 60;
            ss = tod % MIN_SECS;
            reading.out_hour_tens   = 6'(ASCII_ZERO + hh / 10);
            reading.out_hour_ones   = 6'(ASCII_ZERO + hh % 10);
            reading.out_minute_tens = 6'(ASCII_ZERO + mm / 10);
            reading.out_minute_ones = 6'(ASCII_ZERO + mm % 10);
            reading.out_second_tens = 6'(ASCII_ZERO + ss / 10);
            reading.out_second_ones = 6'(ASCII_ZERO + ss % 10);
            effective_count++;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // well-formed "HH:MM:SS" set command
   function automatic req_type set_command(input int unsigned hh, input int unsigned mm,
                                           input int unsigned ss, input logic [31:0] now);
      req_type r;
      r = '0;
      r.func              = FN_SET;
      r.space_char        = ASCII_SPACE;
      r.hour_tens_char    = 8'(ASCII_ZERO + hh / 10);
      r.hour_ones_char    = 8'(ASCII_ZERO + hh % 10);
      r.first_colon_char  = ASCII_COLON;
      r.minute_tens_char  = 8'(ASCII_ZERO + mm / 10);
      r.minute_ones_char  = 8'(ASCII_ZERO + mm % 10);
      r.second_colon_char = ASCII_COLON;
      r.second_tens_char  = 8'(ASCII_ZERO + ss / 10);
      r.second_ones_char  = 8'(ASCII_ZERO + ss % 10);
      r.terminator_char   = ASCII_NUL;
      r.now_ms            = now;
      return r;
   endfunction

   // command with no text: stop, tick or unused code
   function automatic req_type bare_command(input logic [1:0] fn, input logic [31:0] now);
      req_type r;
      r = '0;
      r.func   = fn;
      r.now_ms = now;
      return r;
   endfunction

   // drive one transaction, hold it until accepted, then predict its effect
   task automatic send_request(input req_type item);
      rsp_type reading;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (advance_clock(item, reading))
         pending_readings.push_back(reading);
   endtask

   function automatic void check_digit(input string label, input logic [5:0] want,
                                       input logic [5:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, label, want, got);
         error_count++;
      end
   endfunction

   // compare each reading with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: reading with none expected: expected nothing, got %h",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            check_digit("hour tens", want.out_hour_tens, rsp_data.out_hour_tens);
            check_digit("hour ones", want.out_hour_ones, rsp_data.out_hour_ones);
            check_digit("minute tens", want.out_minute_tens, rsp_data.out_minute_tens);
            check_digit("minute ones", want.out_minute_ones, rsp_data.out_minute_ones);
            check_digit("second tens", want.out_second_tens, rsp_data.out_second_tens);
            check_digit("second ones", want.out_second_ones, rsp_data.out_second_ones);
         end
      end
   end

   // before any set the clock is stopped: no readings, stop and unused code ignored
   task automatic test_stopped_clock();
      send_request(bare_command(FN_TICK, 32'hFFFF_FFFF));
      send_request(bare_command(FN_STOP, 32'h0000_0000));
      send_request(bare_command(FN_UNUSED, 32'h0000_0000));
   endtask

   // second boundaries, end of day, counter wrap and re-set while running
   task automatic test_readings_and_wrap();
      send_request(set_command(0, 0, 0, 32'h0000_0000));
      send_request(bare_command(FN_TICK, 32'd999));
      send_request(bare_command(FN_TICK, 32'd1000));
      send_request(set_command(23, 59, 59, 32'hFFFF_FC18));
      send_request(bare_command(FN_TICK, 32'hFFFF_FFFF));
      // ms counter wrapped: two seconds later, past midnight
      send_request(bare_command(FN_TICK, 32'h0000_03E8));
      // one below the base: largest elapsed count
      send_request(bare_command(FN_TICK, 32'hFFFF_FC17));
      send_request(set_command(12, 34, 56, 32'h8000_0000));
   endtask

   // one fault per frame, all must leave 12:34:56 in place
   task automatic test_malformed_sets();
      req_type r;
      r = set_command(19, 45, 30, 32'h0);
      r.space_char = 8'hFF;
      send_request(r);
      r = set_command(19, 45, 30, 32'h0);
      r.first_colon_char = 8'h00;
      send_request(r);
      r = set_command(19, 45, 30, 32'h0);
      r.second_colon_char = 8'h3B;
      send_request(r);
      r = set_command(19, 45, 30, 32'h0);
      r.terminator_char = 8'hFF;
      send_request(r);
      r = set_command(19, 45, 30, 32'h0);
      r.hour_tens_char = 8'h2F;
      send_request(r);
      r = set_command(19, 45, 30, 32'h0);
      r.second_ones_char = 8'h3A;
      send_request(r);
      send_request(set_command(24, 0, 0, 32'h0));
      send_request(set_command(0, 60, 0, 32'h0));
      send_request(set_command(0, 0, 60, 32'h0));
      r = set_command(1, 2, 3, 32'h0);
      r.func = FN_UNUSED;
      send_request(r);
      send_request(bare_command(FN_TICK, 32'h8000_0000 + 32'd61_000));
   endtask

   // stop halts readings, repeated stop is harmless
   task automatic test_stop_command();
      send_request(bare_command(FN_STOP, 32'h0));
      send_request(bare_command(FN_TICK, 32'h8000_0000 + 32'd62_000));
      send_request(bare_command(FN_STOP, 32'hFFFF_FFFF));
   endtask

   // mostly ticks and good sets with random content, some stops, broken frames and noise
   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned stall_pct,
                                      input int unsigned quota);
      int unsigned  goal, pick;
      req_type      r;
      logic [127:0] noise_bits;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      goal = sent_count + quota;
      while (sent_count < goal) begin
         // wall time: short steps, long jumps, now and then anywhere
         pick = $urandom_range(99);
         if (pick < 80)
            wall_ms += $urandom_range(5000);
         else if (pick < 95)
            wall_ms += $urandom_range(LONG_JUMP_MS);
         else
            wall_ms = $urandom;
         pick = $urandom_range(99);
         if (pick < 60) begin
            r = bare_command(FN_TICK, wall_ms);
         end else if (pick < 72) begin
            r = set_command($urandom_range(23), $urandom_range(59), $urandom_range(59),
                            wall_ms);
         end else if (pick < 77) begin
            r = bare_command(FN_STOP, wall_ms);
         end else if (pick < 92) begin
            r = set_command($urandom_range(23), $urandom_range(59), $urandom_range(59),
                            wall_ms);
            case ($urandom_range(9))
               0: r.space_char        = 8'($urandom_range(255));
               1: r.first_colon_char  = 8'($urandom_range(255));
               2: r.second_colon_char = 8'($urandom_range(255));
               3: r.terminator_char   = 8'($urandom_range(255));
               4: r.hour_tens_char    = 8'($urandom_range(255));
               5: r.hour_ones_char    = 8'($urandom_range(255));
               6: r.minute_tens_char  = 8'($urandom_range(255));
               7: r.minute_ones_char  = 8'($urandom_range(255));
               8: r.second_tens_char  = 8'($urandom_range(255));
               default: r.second_ones_char = 8'($urandom_range(255));
            endcase
         end else begin
            noise_bits = {$urandom, $urandom, $urandom, $urandom};
            r = noise_bits[$bits(req_type)-1:0];
         end
         send_request(r);
      end
   endtask

   // release the request channel and collect the last readings
   task automatic drain_readings();
      int unsigned guard;
      guard = 0;
      @(negedge clock);
      req_valid      <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (pending_readings.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      if (pending_readings.size() != 0) begin
         $display("%0t: %0d expected readings never arrived", $time, pending_readings.size());
         error_count++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_stopped_clock();
      test_readings_and_wrap();
      test_malformed_sets();
      test_stop_command();
      test_random_traffic(0, 0, 106);
      test_random_traffic(53, 0, 106);
      test_random_traffic(0, 53, 106);
      test_random_traffic(20, 20, 106);
      drain_readings();
      $display("tb_top: %0d requests, %0d readings checked, %0d sets taken, %0d dropped, %0d stops",
               sent_count, readings_checked, sets_taken, sets_dropped, stop_count);
      $display("tb_top: traffic ran steady, with sender gaps, receiver stalls and both");
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   // hang guard, far beyond the slowest good run
   initial begin
      #5_000_000;
      $display("tb_top: timeout at %0t", $time);
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
